@@ rtl/core/pfr_pkg.sv @@
//------------------------------------------------------------------------------
// pfr_pkg: shared types and constants of the Pareto front ranker
// Field widths, stream layout, the queued command and the result record.
//------------------------------------------------------------------------------
package pfr_pkg;

    localparam int POINTS_MAX_DEF = 16;
    localparam int QUEUE_DEPTH    = 2;

    localparam int PERF_W      = 32;
    localparam int COST_W      = 31;
    localparam int SEL_W       = 4;
    localparam int SEL_RESET   = 3;
    localparam int IDX_OUT_W   = 4;
    localparam int FRONT_OUT_W = 5;

    localparam int S_TDATA_W = 64;
    localparam int M_TDATA_W = 16;

    // one accepted point as seen by the ranking engine
    typedef struct packed {
        logic                     load;
        logic                     last;
        logic signed [PERF_W-1:0] perf;
        logic [COST_W-1:0]        cost;
    } pfr_cmd_t;

    typedef struct packed {
        logic [IDX_OUT_W-1:0]   point_index;
        logic [FRONT_OUT_W-1:0] front_number;
        logic                   on_edge_front;
        logic [FRONT_OUT_W-1:0] edge_front;
        logic                   last_result;
    } pfr_result_t;

endpackage

@@ rtl/core/pfr_ram.sv @@
//------------------------------------------------------------------------------
// pfr_ram: generic single-write, single-read RAM
// One write port and one read port with registered, enabled read data.
//------------------------------------------------------------------------------
module pfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/core/pfr_front.sv @@
//------------------------------------------------------------------------------
// pfr_front: input side of the ranker
// Accept points, classify each as stored or dropped and push it to the queue.
//------------------------------------------------------------------------------
module pfr_front #(
    parameter int POINTS_MAX = pfr_pkg::POINTS_MAX_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [pfr_pkg::S_TDATA_W-1:0]    s_axis_tdata,
    input  logic                             s_axis_tlast,
    output logic                             push_valid,
    input  logic                             push_ready,
    output pfr_pkg::pfr_cmd_t                push_cmd
);
    import pfr_pkg::*;

    localparam int CNT_W = $clog2(POINTS_MAX + 1);

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             take;

    assign s_axis_tready = push_ready;
    assign push_valid    = s_axis_tvalid;
    assign take          = s_axis_tvalid && push_ready;

    always_comb begin
        push_cmd.perf = s_axis_tdata[PERF_W-1:0];
        push_cmd.cost = s_axis_tdata[PERF_W+COST_W-1:PERF_W];
        push_cmd.last = s_axis_tlast;
        // drop once the store is full
        push_cmd.load = (count_reg < CNT_W'(POINTS_MAX));
    end

    always_comb begin
        count_next = count_reg;
        if (take) begin
            if (s_axis_tlast) begin
                count_next = '0;
            end else if (push_cmd.load) begin
                count_next = count_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

endmodule

@@ rtl/core/pfr_queue.sv @@
//------------------------------------------------------------------------------
// pfr_queue: short command queue
// Decouple the accepting front from the ranking engine.
//------------------------------------------------------------------------------
module pfr_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push_valid,
    output logic              push_ready,
    input  pfr_pkg::pfr_cmd_t push_cmd,
    output logic              pop_valid,
    input  logic              pop_ready,
    output pfr_pkg::pfr_cmd_t pop_cmd
);
    import pfr_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    pfr_cmd_t         slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] fill_reg;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (fill_reg != CNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (fill_reg != '0);
    assign pop_cmd    = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                fill_reg <= fill_reg + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                fill_reg <= fill_reg - CNT_W'(1);
            end
        end
    end

endmodule

@@ rtl/core/pfr_back.sv @@
//------------------------------------------------------------------------------
// pfr_back: ranking engine
// Store points, run layered front passes with one pairwise test a cycle,
// then emit one result per point through a registered output stage.
//------------------------------------------------------------------------------
module pfr_back #(
    parameter int POINTS_MAX = pfr_pkg::POINTS_MAX_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cmd_valid,
    output logic                        cmd_ready,
    input  pfr_pkg::pfr_cmd_t           cmd,
    input  logic [pfr_pkg::SEL_W-1:0]   select_count,
    output logic                        res_valid,
    input  logic                        res_ready,
    output pfr_pkg::pfr_result_t        res
);
    import pfr_pkg::*;

    localparam int IDX_W   = $clog2(POINTS_MAX);
    localparam int CNT_W   = $clog2(POINTS_MAX + 1);
    localparam int FRONT_W = CNT_W;
    localparam int PT_W    = PERF_W + COST_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_I_CHECK,
        ST_I_FETCH,
        ST_J_SCAN,
        ST_PASS_END,
        ST_OUT_REQ,
        ST_OUT_PUT
    } state_t;

    state_t                   state_reg;
    logic [CNT_W-1:0]         cnt_reg;
    logic [CNT_W-1:0]         ranked_reg;
    logic [FRONT_W-1:0]       front_reg;
    logic [FRONT_W-1:0]       edge_front_reg;
    logic [IDX_W-1:0]         i_reg;
    logic [IDX_W-1:0]         j_reg;
    logic [IDX_W-1:0]         k_reg;
    logic signed [PERF_W-1:0] perf_i_reg;
    logic [COST_W-1:0]        cost_i_reg;
    logic [POINTS_MAX-1:0]    unranked_reg;
    logic [POINTS_MAX-1:0]    newly_reg;
    logic                     res_valid_reg;
    pfr_result_t              res_reg;

    logic                     pt_wr_en;
    logic                     pt_rd_en;
    logic [IDX_W-1:0]         pt_rd_addr;
    logic [PT_W-1:0]          pt_rd_data;
    logic signed [PERF_W-1:0] perf_j;
    logic [COST_W-1:0]        cost_j;
    logic                     fr_wr_en;
    logic                     fr_rd_en;
    logic [FRONT_W-1:0]       fr_rd_data;
    logic [FRONT_W-1:0]       front_val;
    logic                     beats;
    logic                     i_last;
    logic                     j_last;
    logic                     k_last;
    logic                     out_free;
    logic                     stop;

    pfr_ram #(
        .WIDTH (PT_W),
        .DEPTH (POINTS_MAX)
    ) u_point_ram (
        .aclk    (aclk),
        .wr_en   (pt_wr_en),
        .wr_addr (cnt_reg[IDX_W-1:0]),
        .wr_data ({cmd.cost, cmd.perf}),
        .rd_en   (pt_rd_en),
        .rd_addr (pt_rd_addr),
        .rd_data (pt_rd_data)
    );

    pfr_ram #(
        .WIDTH (FRONT_W),
        .DEPTH (POINTS_MAX)
    ) u_front_ram (
        .aclk    (aclk),
        .wr_en   (fr_wr_en),
        .wr_addr (i_reg),
        .wr_data (front_reg),
        .rd_en   (fr_rd_en),
        .rd_addr (k_reg),
        .rd_data (fr_rd_data)
    );

    assign cmd_ready = (state_reg == ST_IDLE);
    assign pt_wr_en  = (state_reg == ST_IDLE) && cmd_valid && cmd.load;
    assign perf_j    = pt_rd_data[PERF_W-1:0];
    assign cost_j    = pt_rd_data[PT_W-1:PERF_W];

    assign i_last = ((CNT_W'(i_reg) + CNT_W'(1)) == cnt_reg);
    assign j_last = ((CNT_W'(j_reg) + CNT_W'(1)) == cnt_reg);
    assign k_last = ((CNT_W'(k_reg) + CNT_W'(1)) == cnt_reg);

    // only points unranked at the start of the pass may dominate
    assign beats = unranked_reg[j_reg] && (j_reg != i_reg) &&
                   (((perf_j >= perf_i_reg) && (cost_j < cost_i_reg)) ||
                    ((perf_j > perf_i_reg) && (cost_j <= cost_i_reg)));

    assign fr_wr_en  = (state_reg == ST_J_SCAN) && !beats && j_last;
    assign fr_rd_en  = (state_reg == ST_OUT_REQ);
    assign front_val = unranked_reg[k_reg] ? '0 : fr_rd_data;
    assign out_free  = !res_valid_reg || res_ready;
    assign stop      = (int'(ranked_reg) > int'(select_count)) || (ranked_reg >= cnt_reg);

    always_comb begin
        pt_rd_en   = 1'b0;
        pt_rd_addr = i_reg;
        case (state_reg)
            ST_I_CHECK: begin
                pt_rd_en   = unranked_reg[i_reg];
                pt_rd_addr = i_reg;
            end
            ST_I_FETCH: begin
                pt_rd_en   = 1'b1;
                pt_rd_addr = '0;
            end
            ST_J_SCAN: begin
                pt_rd_en   = 1'b1;
                pt_rd_addr = j_reg + IDX_W'(1);
            end
            default: begin
                pt_rd_en   = 1'b0;
                pt_rd_addr = i_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            ranked_reg    <= '0;
            front_reg     <= FRONT_W'(1);
            unranked_reg  <= '0;
            newly_reg     <= '0;
            res_valid_reg <= 1'b0;
        end else begin
            // drop the valid once taken, unless a new result replaces it
            if (res_valid_reg && res_ready && (state_reg != ST_OUT_PUT)) begin
                res_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (cmd_valid) begin
                        if (cmd.load) begin
                            unranked_reg[cnt_reg[IDX_W-1:0]] <= 1'b1;
                            cnt_reg <= cnt_reg + CNT_W'(1);
                        end
                        if (cmd.last) begin
                            i_reg     <= '0;
                            state_reg <= ST_I_CHECK;
                        end
                    end
                end
                ST_I_CHECK: begin
                    if (unranked_reg[i_reg]) begin
                        state_reg <= ST_I_FETCH;
                    end else if (i_last) begin
                        state_reg <= ST_PASS_END;
                    end else begin
                        i_reg <= i_reg + IDX_W'(1);
                    end
                end
                ST_I_FETCH: begin
                    perf_i_reg <= perf_j;
                    cost_i_reg <= cost_j;
                    j_reg      <= '0;
                    state_reg  <= ST_J_SCAN;
                end
                ST_J_SCAN: begin
                    if (beats || j_last) begin
                        if (!beats) begin
                            newly_reg[i_reg] <= 1'b1;
                            ranked_reg       <= ranked_reg + CNT_W'(1);
                        end
                        if (i_last) begin
                            state_reg <= ST_PASS_END;
                        end else begin
                            i_reg     <= i_reg + IDX_W'(1);
                            state_reg <= ST_I_CHECK;
                        end
                    end else begin
                        j_reg <= j_reg + IDX_W'(1);
                    end
                end
                ST_PASS_END: begin
                    unranked_reg <= unranked_reg & ~newly_reg;
                    newly_reg    <= '0;
                    if (stop) begin
                        edge_front_reg <= front_reg;
                        k_reg          <= '0;
                        state_reg      <= ST_OUT_REQ;
                    end else begin
                        front_reg <= front_reg + FRONT_W'(1);
                        i_reg     <= '0;
                        state_reg <= ST_I_CHECK;
                    end
                end
                ST_OUT_REQ: begin
                    state_reg <= ST_OUT_PUT;
                end
                ST_OUT_PUT: begin
                    if (out_free) begin
                        res_valid_reg         <= 1'b1;
                        res_reg.point_index   <= IDX_OUT_W'(k_reg);
                        res_reg.front_number  <= FRONT_OUT_W'(front_val);
                        res_reg.on_edge_front <= (front_val != '0) &&
                                                 (front_val == edge_front_reg);
                        res_reg.edge_front    <= FRONT_OUT_W'(edge_front_reg);
                        res_reg.last_result   <= k_last;
                        if (k_last) begin
                            cnt_reg      <= '0;
                            ranked_reg   <= '0;
                            front_reg    <= FRONT_W'(1);
                            unranked_reg <= '0;
                            state_reg    <= ST_IDLE;
                        end else begin
                            k_reg     <= k_reg + IDX_W'(1);
                            state_reg <= ST_OUT_REQ;
                        end
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

@@ rtl/core/pareto_front_ranker_core.sv @@
// Ranking: the last point of a set starts ranking, over up to n passes (n points held);
//   each pass tests every point still unranked at its start against the others.
// Throughput: one point a cycle while the engine is idle; points wait while a set is
//   ranked or its results go out.
// Reset: synchronous, active low; clears the set, the queue and the output stage and
//   sets select_count to 3. Point and front stores are not cleared and need no pass.
//------------------------------------------------------------------------------
// pareto_front_ranker_core: layered Pareto front assignment
// Load a set of (performance, cost) points, rank them into non-dominated
// fronts on the last point, and stream out one result per stored point.
//------------------------------------------------------------------------------
module pareto_front_ranker_core #(
    parameter int POINTS_MAX = pfr_pkg::POINTS_MAX_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // configuration: select_count
    input  logic                          cfg_wr_en,
    input  logic [pfr_pkg::SEL_W-1:0]     cfg_wr_data,
    // point stream
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [pfr_pkg::S_TDATA_W-1:0] s_axis_tdata,  // point_performance, point_cost
    input  logic                          s_axis_tlast,  // last_point
    // result stream
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [pfr_pkg::M_TDATA_W-1:0] m_axis_tdata,  // point_index, front_number,
                                                         // edge_front
    output logic                          m_axis_tuser,  // on_edge_front
    output logic                          m_axis_tlast   // last_result
);
    import pfr_pkg::*;

    logic [SEL_W-1:0] select_count_reg;
    logic             q_push_valid;
    logic             q_push_ready;
    pfr_cmd_t         q_push_cmd;
    logic             q_pop_valid;
    logic             q_pop_ready;
    pfr_cmd_t         q_pop_cmd;
    pfr_result_t      result;

    // Hold the ranking threshold; the user must write it only while the block is idle (not enforced here).
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            select_count_reg <= SEL_W'(SEL_RESET);
        end else if (cfg_wr_en) begin
            select_count_reg <= cfg_wr_data;
        end
    end

    // Front: accept each transaction, decide store or drop, push it on.
    pfr_front #(
        .POINTS_MAX (POINTS_MAX)
    ) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .push_valid    (q_push_valid),
        .push_ready    (q_push_ready),
        .push_cmd      (q_push_cmd)
    );

    // Queue: let loading run ahead while the engine is busy.
    pfr_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (q_push_valid),
        .push_ready (q_push_ready),
        .push_cmd   (q_push_cmd),
        .pop_valid  (q_pop_valid),
        .pop_ready  (q_pop_ready),
        .pop_cmd    (q_pop_cmd)
    );

    // Back: store points, rank on the last one, emit results in load order.
    pfr_back #(
        .POINTS_MAX (POINTS_MAX)
    ) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd_valid    (q_pop_valid),
        .cmd_ready    (q_pop_ready),
        .cmd          (q_pop_cmd),
        .select_count (select_count_reg),
        .res_valid    (m_axis_tvalid),
        .res_ready    (m_axis_tready),
        .res          (result)
    );

    // Pack the result transaction, first field in the lowest bits.
    assign m_axis_tdata = {{(M_TDATA_W - IDX_OUT_W - 2 * FRONT_OUT_W){1'b0}},
                           result.edge_front, result.front_number, result.point_index};
    assign m_axis_tuser = result.on_edge_front;
    assign m_axis_tlast = result.last_result;

endmodule

@@ verif/pfr_ranking_checker.sv @@
`timescale 1ns / 100ps
//------------------------------------------------------------------------------
// pfr_ranking_checker: result predictor and comparator for the front ranker
// Watches the point, result and select_count channels, ranks each completed
// set on its own and compares every result transaction in order.
//------------------------------------------------------------------------------
module pfr_ranking_checker (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [pfr_pkg::SEL_W-1:0]     cfg_wr_data,
    input  logic                          s_axis_tvalid,
    input  logic                          s_axis_tready,
    input  logic [pfr_pkg::S_TDATA_W-1:0] s_axis_tdata,
    input  logic                          s_axis_tlast,
    input  logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    input  logic [pfr_pkg::M_TDATA_W-1:0] m_axis_tdata,
    input  logic                          m_axis_tuser,
    input  logic                          m_axis_tlast,
    output int                            mismatch_count,
    output int                            pending_results,
    output int                            results_checked
);
    import pfr_pkg::*;

    localparam int DEPTH = POINTS_MAX_DEF;

    logic signed [PERF_W-1:0] perf_mem  [DEPTH];
    logic [COST_W-1:0]        cost_mem  [DEPTH];
    logic [FRONT_OUT_W-1:0]   front_mem [DEPTH];
    int                       held_points = 0;
    logic [SEL_W-1:0]         select_count = SEL_W'(SEL_RESET);
    pfr_result_t              front_results_q [$];

    // j beats i: no worse on both axes and strictly better on one
    function automatic bit beats_point(int j, int i);
        return (perf_mem[j] >= perf_mem[i] && cost_mem[j] <  cost_mem[i]) ||
               (perf_mem[j] >  perf_mem[i] && cost_mem[j] <= cost_mem[i]);
    endfunction

    task automatic rank_held_set();
        int                     ranked;
        logic [FRONT_OUT_W-1:0] front;
        bit                     finished;
        bit                     beaten;
        pfr_result_t            r;
        ranked   = 0;
        front    = FRONT_OUT_W'(1);
        finished = 0;
        while (!finished) begin
            for (int i = 0; i < held_points; i++) begin
                if (front_mem[i] == 0) begin
                    beaten = 0;
                    for (int j = 0; j < held_points && !beaten; j++) begin
                        // skip points already placed on an earlier front
                        if (j != i && !(front_mem[j] != 0 && front_mem[j] < front))
                            beaten = beats_point(j, i);
                    end
                    if (!beaten) begin
                        front_mem[i] = front;
                        ranked++;
                    end
                end
            end
            if (ranked > select_count || ranked >= held_points)
                finished = 1;
            else
                front++;
        end
        for (int i = 0; i < held_points; i++) begin
            r.point_index   = IDX_OUT_W'(i);
            r.front_number  = front_mem[i];
            r.on_edge_front = (front_mem[i] != 0 && front_mem[i] == front);
            r.edge_front    = front;
            r.last_result   = (i == held_points - 1);
            front_results_q.insert(front_results_q.size(), r);
        end
        foreach (front_mem[k]) front_mem[k] = '0;
        held_points = 0;
    endtask

    always @(posedge aclk) begin : monitor
        pfr_result_t got;
        pfr_result_t want;
        if (!aresetn) begin
            held_points     = 0;
            select_count    = SEL_W'(SEL_RESET);
            mismatch_count  = 0;
            results_checked = 0;
            foreach (front_mem[k]) front_mem[k] = '0;
            front_results_q.delete();
        end else begin
            if (cfg_wr_en)
                select_count = cfg_wr_data;

            if (m_axis_tvalid && m_axis_tready) begin
                got.point_index   = m_axis_tdata[3:0];
                got.front_number  = m_axis_tdata[8:4];
                got.edge_front    = m_axis_tdata[13:9];
                got.on_edge_front = m_axis_tuser;
                got.last_result   = m_axis_tlast;
                if (front_results_q.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("%0t: result with none pending: idx=%0d front=%0d",
                                 $realtime, got.point_index, got.front_number);
                end else begin
                    want = front_results_q.pop_front();
                    results_checked++;
                    if (got.point_index   !== want.point_index   ||
                        got.front_number  !== want.front_number  ||
                        got.on_edge_front !== want.on_edge_front ||
                        got.edge_front    !== want.edge_front    ||
                        got.last_result   !== want.last_result) begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display({"%0t: result mismatch, expected idx=%0d front=%0d ",
                                      "on_edge=%0b edge=%0d last=%0b, got idx=%0d ",
                                      "front=%0d on_edge=%0b edge=%0d last=%0b"},
                                     $realtime, want.point_index, want.front_number,
                                     want.on_edge_front, want.edge_front, want.last_result,
                                     got.point_index, got.front_number, got.on_edge_front,
                                     got.edge_front, got.last_result);
                    end
                end
            end

            if (s_axis_tvalid && s_axis_tready) begin
                // a full store drops the point, the last one still ranks the set
                if (held_points < DEPTH) begin
                    perf_mem[held_points]  = s_axis_tdata[31:0];
                    cost_mem[held_points]  = s_axis_tdata[62:32];
                    front_mem[held_points] = '0;
                    held_points++;
                end
                if (s_axis_tlast)
                    rank_held_set();
            end
        end
        pending_results = front_results_q.size();
    end

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 100ps
//------------------------------------------------------------------------------
// tb_top: stimulus and verdict for the Pareto front ranker core
// Streams directed and random point sets under several select_count settings,
// with bursty input and a stalling result side; the checker does the scoring.
//------------------------------------------------------------------------------
module tb_top;
    import pfr_pkg::*;

    localparam logic signed [PERF_W-1:0] PERF_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [PERF_W-1:0] PERF_MIN = 32'sh8000_0000;
    localparam logic [COST_W-1:0]        COST_MAX = 31'h7FFF_FFFF;

    logic                   aclk          = 1'b0;
    logic                   aresetn       = 1'b0;
    logic                   cfg_wr_en     = 1'b0;
    logic [SEL_W-1:0]       cfg_wr_data   = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [S_TDATA_W-1:0]   s_axis_tdata  = '0;   // point_performance, point_cost
    logic                   s_axis_tlast  = 1'b0; // last_point
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0]   m_axis_tdata;         // point_index, front_number, edge_front
    logic                   m_axis_tuser;         // on_edge_front
    logic                   m_axis_tlast;         // last_result

    int mismatch_count;
    int pending_results;
    int results_checked;

    int points_sent   = 0;
    int sets_sent     = 0;
    int settings_used = 0;
    int burst_left    = 0;

    // 20 ns period
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    pareto_front_ranker_core uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    pfr_ranking_checker u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .s_axis_tvalid   (s_axis_tvalid),
        .s_axis_tready   (s_axis_tready),
        .s_axis_tdata    (s_axis_tdata),
        .s_axis_tlast    (s_axis_tlast),
        .m_axis_tvalid   (m_axis_tvalid),
        .m_axis_tready   (m_axis_tready),
        .m_axis_tdata    (m_axis_tdata),
        .m_axis_tuser    (m_axis_tuser),
        .m_axis_tlast    (m_axis_tlast),
        .mismatch_count  (mismatch_count),
        .pending_results (pending_results),
        .results_checked (results_checked)
    );

    // Result side back-pressure: switch at random among four stall patterns,
    // one of them never stalling at all.
    int rx_mode = 0;
    int rx_left = 0;
    int rx_hold = 0;

    always @(posedge aclk) begin
        if (rx_left == 0) begin
            rx_mode = $urandom_range(0, 3);
            rx_left = $urandom_range(50, 300);
        end
        rx_left--;
        case (rx_mode)
            0: m_axis_tready <= 1'b1;
            1: m_axis_tready <= ($urandom_range(0, 9) < 7);
            2: m_axis_tready <= (rx_left % 4 == 0);
            default: begin
                // long stalls now and then
                if (rx_hold > 0) begin
                    rx_hold--;
                    m_axis_tready <= 1'b0;
                end else begin
                    m_axis_tready <= 1'b1;
                    if ($urandom_range(0, 7) == 0)
                        rx_hold = $urandom_range(5, 20);
                end
            end
        endcase
    end

    // Drive one point and hold it until the transaction completes. The sender
    // runs in bursts; a new burst may open with a gap of idle cycles.
    task automatic send_point(input logic signed [PERF_W-1:0] perf,
                              input logic [COST_W-1:0] cost, input logic last);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_axis_tdata  <= {1'b0, cost, perf};
        s_axis_tlast  <= last;
        s_axis_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        points_sent++;
        if (last)
            sets_sent++;
    endtask

    // Drain every pending result, let the engine settle, then write
    // select_count while the block is idle.
    task automatic set_select_count(input logic [SEL_W-1:0] sel);
        s_axis_tvalid <= 1'b0;
        @(posedge aclk);
        wait (pending_results == 0);
        repeat (40) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= sel;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        settings_used++;
    endtask

    // Strict chain: each point is beaten by every earlier one, so point k
    // lands on front k+1 when enough passes run.
    task automatic send_chain(input int count);
        for (int k = 0; k < count; k++)
            send_point(PERF_W'(1000 - k), COST_W'(k), k == count - 1);
    endtask

    task automatic send_random_set(input int count);
        int                       style;
        int                       base;
        logic signed [PERF_W-1:0] perf;
        logic [COST_W-1:0]        cost;
        style = $urandom_range(0, 3);
        for (int k = 0; k < count; k++) begin
            case (style)
                0: begin
                    // narrow range: plenty of ties and equal points
                    perf = $urandom_range(0, 7) - 4;
                    cost = COST_W'($urandom_range(0, 7));
                end
                1: begin
                    perf = $urandom;
                    cost = COST_W'($urandom);
                end
                2: begin
                    // roughly anti-correlated: wide first fronts
                    base = $urandom_range(0, 15);
                    perf = base * 16 + $urandom_range(0, 3);
                    cost = COST_W'((15 - base) * 16 + $urandom_range(0, 20));
                end
                default: begin
                    case ($urandom_range(0, 4))
                        0: perf = PERF_MIN;
                        1: perf = PERF_MAX;
                        2: perf = '0;
                        3: perf = '1;
                        default: perf = $urandom;
                    endcase
                    case ($urandom_range(0, 2))
                        0: cost = '0;
                        1: cost = COST_MAX;
                        default: cost = COST_W'($urandom);
                    endcase
                end
            endcase
            send_point(perf, cost, k == count - 1);
        end
    endtask

    initial begin : stimulus
        int phase_start;
        int set_size;
        logic [SEL_W-1:0] sel;

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed, at the reset select_count: a lone point at the extremes,
        // then a mixed set with a pair of equal points.
        send_point(PERF_MIN, COST_MAX, 1'b1);
        send_point(PERF_MAX, '0, 1'b0);
        send_point(PERF_MIN, COST_MAX, 1'b0);
        send_point('0, 31'd5, 1'b0);
        send_point('0, 31'd5, 1'b1);

        // select_count zero: a single pass only
        set_select_count('0);
        send_chain(3);

        // Widest setting: a full chain ranked to front 16, plus one point over
        // capacity that is dropped but still closes the set.
        set_select_count(4'd15);
        for (int k = 0; k < 16; k++)
            send_point(PERF_W'(1000 - k), COST_W'(k), 1'b0);
        send_point(PERF_MAX, '0, 1'b1);

        // Random phases: select_count 1 and 15 first, then arbitrary settings from 1 to 15.
        for (int ph = 0; ph < 7; ph++) begin
            sel = (ph == 0) ? 4'd1 : (ph == 1) ? 4'd15 : SEL_W'($urandom_range(1, 15));
            set_select_count(sel);
            phase_start = points_sent;
            while (points_sent - phase_start < 45) begin
                // mostly small sets, now and then a full or overfull one
                set_size = ($urandom_range(0, 9) == 0) ? $urandom_range(16, 18)
                                                       : $urandom_range(1, 8);
                send_random_set(set_size);
            end
        end

        s_axis_tvalid <= 1'b0;
        @(posedge aclk);
        wait (pending_results == 0);
        repeat (200) @(posedge aclk);

        $display("Sent %0d points in %0d sets across %0d select_count settings;",
                 points_sent, sets_sent, settings_used + 1);
        $display("compared %0d ranked results.", results_checked);
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin
        #10_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule

@@ files.f @@
rtl/core/pfr_pkg.sv
rtl/core/pfr_ram.sv
rtl/core/pfr_front.sv
rtl/core/pfr_queue.sv
rtl/core/pfr_back.sv
rtl/core/pareto_front_ranker_core.sv
verif/pfr_ranking_checker.sv
verif/tb_top.sv
